/* src/mhsd_pkg.sv */
// ----------------------------------------------------------------------------
// mhsd_pkg
// Shared types, constants and the arctangent table of the heading unit.
// ----------------------------------------------------------------------------
package mhsd_pkg;

    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 17;
    localparam int unsigned StepW    = 5;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_MIN_FIELD = 3'd0,
        CFG_ALPHA     = 3'd1,
        CFG_STABLE    = 3'd2,
        CFG_OFFSET    = 3'd3,
        CFG_INIT_ROT  = 3'd4
    } cfg_idx_t;

    localparam logic [16:0] AlphaDefault  = 17'd1966;
    localparam logic [16:0] AlphaOne      = 17'd65536;
    localparam logic [15:0] StableDefault = 16'd18;
    localparam logic [16:0] FullTurn      = 17'd46080;
    localparam logic [16:0] HalfSector    = 17'd7680;
    localparam logic [16:0] SectorSpan    = 17'd15360;
    localparam logic signed [31:0] Z180   = 32'sd188743680;
    localparam logic signed [31:0] Z360   = 32'sd377487360;
    localparam logic [31:0] HeadRound     = 32'd4096;
    localparam logic [14:0] CompMax       = 15'h7fff;
    localparam logic [31:0] SqrtBitInit   = 32'h4000_0000;
    localparam logic [StepW-1:0] DivLast  = 5'd30;
    localparam logic [StepW-1:0] SqrtLast = 5'd15;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQX,
        OP_SQY,
        OP_MINSQ,
        OP_CHECK,
        OP_DIVI,
        OP_DIV,
        OP_SQI,
        OP_SQRT,
        OP_NWR,
        OP_FIRST,
        OP_B1,
        OP_B2,
        OP_BW,
        OP_FCOPY,
        OP_FLOAD,
        OP_CORI,
        OP_COR,
        OP_HEAD,
        OP_SECT,
        OP_DEB
    } op_t;

    typedef struct packed {
        op_t              op;
        logic             comp;
        logic [StepW-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic sample_ok;
        logic have_sample;
        logic sum_zero;
    } status_t;

    function automatic logic signed [31:0] atan_entry(input logic [StepW-1:0] i);
        logic signed [31:0] v;
        unique case (i)
            5'd0:  v = 32'sd47185920;
            5'd1:  v = 32'sd27855475;
            5'd2:  v = 32'sd14718068;
            5'd3:  v = 32'sd7471121;
            5'd4:  v = 32'sd3750058;
            5'd5:  v = 32'sd1876857;
            5'd6:  v = 32'sd938658;
            5'd7:  v = 32'sd469357;
            5'd8:  v = 32'sd234682;
            5'd9:  v = 32'sd117342;
            5'd10: v = 32'sd58671;
            5'd11: v = 32'sd29335;
            5'd12: v = 32'sd14668;
            5'd13: v = 32'sd7334;
            5'd14: v = 32'sd3667;
            5'd15: v = 32'sd1833;
            5'd16: v = 32'sd917;
            5'd17: v = 32'sd458;
            5'd18: v = 32'sd229;
            5'd19: v = 32'sd115;
            5'd20: v = 32'sd57;
            5'd21: v = 32'sd29;
            5'd22: v = 32'sd14;
            5'd23: v = 32'sd7;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

/* src/mhsd_datapath.sv */
// ----------------------------------------------------------------------------
// mhsd_datapath
// Shared multiplier, restoring divider, square root, filter, CORDIC,
// sector quantizer and debounce registers.
// ----------------------------------------------------------------------------
module mhsd_datapath
    import mhsd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  logic [15:0]         in_x,
    input  logic [15:0]         in_y,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    output status_t             status,
    output logic                accepted,
    output logic [15:0]         heading,
    output logic [1:0]          candidate,
    output logic [1:0]          rotation,
    output logic                changed
);

    logic [15:0] min_reg;
    logic [16:0] alpha_reg;
    logic [15:0] stable_reg;
    logic [15:0] offset_reg;

    logic signed [15:0] fx_reg, fy_reg;
    logic               have_reg;
    logic [15:0]        heading_reg;
    logic [1:0]         cand_reg, rot_reg, cand_calc_reg;
    logic [15:0]        count_reg;
    logic               accepted_reg, changed_reg;

    logic signed [15:0] vx_reg, vy_reg;
    logic [31:0]        ssum_reg, minsq_reg;
    logic [31:0]        r_reg;
    logic [30:0]        q_reg;
    logic               lsb_reg;
    logic [31:0]        sv_reg, res_reg, bit_reg;
    logic signed [35:0] t_reg;
    logic signed [31:0] cx_reg, cy_reg, cz_reg;

    logic signed [17:0] mul_a, mul_b;
    logic signed [35:0] prod;
    logic [16:0]        alpha_eff, alpha_inv;

    always_comb
    begin
        alpha_eff = (alpha_reg == 17'd0 || alpha_reg > AlphaOne) ? AlphaDefault : alpha_reg;
        alpha_inv = AlphaOne - alpha_eff;
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_SQX:   begin mul_a = 18'(vx_reg); mul_b = 18'(vx_reg); end
            OP_SQY:   begin mul_a = 18'(vy_reg); mul_b = 18'(vy_reg); end
            OP_MINSQ: begin mul_a = {2'b0, min_reg}; mul_b = {2'b0, min_reg}; end
            OP_DIVI:
            begin
                mul_a = cmd.comp ? 18'(vy_reg) : 18'(vx_reg);
                mul_b = mul_a;
            end
            OP_B1:
            begin
                mul_a = {1'b0, alpha_inv};
                mul_b = cmd.comp ? 18'(fy_reg) : 18'(fx_reg);
            end
            OP_B2:
            begin
                mul_a = {1'b0, alpha_eff};
                mul_b = cmd.comp ? 18'(vy_reg) : 18'(vx_reg);
            end
            default: ;
        endcase
        prod = mul_a * mul_b;
    end

    // divider step
    logic        in_bit;
    logic [32:0] r2, rdiff;
    logic        r_ge;
    assign in_bit = (cmd.step == '0) ? lsb_reg : 1'b0;
    assign r2     = {r_reg, in_bit};
    assign r_ge   = r2 >= {1'b0, ssum_reg};
    assign rdiff  = r2 - {1'b0, ssum_reg};

    // square root step
    logic [31:0] sq_sum;
    assign sq_sum = res_reg + bit_reg;

    // normalized component
    logic [14:0]        mag;
    logic signed [15:0] norm_val;
    logic               comp_neg;
    assign mag      = (res_reg > 32'(CompMax)) ? CompMax : res_reg[14:0];
    assign comp_neg = cmd.comp ? vy_reg[15] : vx_reg[15];
    assign norm_val = comp_neg ? (16'sd0 - $signed({1'b0, mag})) : $signed({1'b0, mag});

    // blend rounding, half away from zero
    logic signed [35:0] rpos, rneg;
    logic [15:0]        bw_val;
    assign rpos   = (t_reg + 36'sd32768) >>> 16;
    assign rneg   = (36'sd32768 - t_reg) >>> 16;
    assign bw_val = t_reg[35] ? (16'd0 - rneg[15:0]) : rpos[15:0];

    // CORDIC
    logic signed [31:0] xi, yi, dx, dy, atan_v;
    assign xi     = {{8{fx_reg[15]}}, fx_reg, 8'b0};
    assign yi     = {{8{fy_reg[15]}}, fy_reg, 8'b0};
    assign dx     = cy_reg >>> cmd.step;
    assign dy     = cx_reg >>> cmd.step;
    assign atan_v = atan_entry(cmd.step);

    logic signed [31:0] zw;
    logic [31:0]        hs, hw;
    logic [15:0]        heading_next;
    assign zw = (cz_reg < 0) ? cz_reg + Z360 : cz_reg;
    assign hs = ($unsigned(zw) + HeadRound) >> 13;
    assign hw = (hs >= 32'(FullTurn)) ? hs - 32'(FullTurn) : hs;
    assign heading_next = (fx_reg == 16'sd0 && fy_reg == 16'sd0) ? 16'd0 : hw[15:0];

    // sector
    logic [16:0] off, adj, adj2, pos;
    logic [1:0]  cand_next;
    always_comb
    begin
        off  = ({1'b0, offset_reg} >= FullTurn) ? {1'b0, offset_reg} - FullTurn
                                                : {1'b0, offset_reg};
        adj  = {1'b0, heading_reg} + FullTurn - off;
        adj2 = (adj >= FullTurn) ? adj - FullTurn : adj;
        pos  = adj2 + HalfSector;
        if (pos < SectorSpan)
            cand_next = 2'd0;
        else if (pos < 17'(2 * SectorSpan))
            cand_next = 2'd1;
        else if (pos < FullTurn)
            cand_next = 2'd2;
        else
            cand_next = 2'd0;
    end

    // debounce
    logic [15:0] need, count_inc;
    assign need      = (stable_reg == 16'd0) ? StableDefault : stable_reg;
    assign count_inc = (count_reg == 16'hffff) ? count_reg : count_reg + 16'd1;

    logic [1:0] rot_init;
    assign rot_init = (cfg_data[1:0] == 2'd3) ? 2'd0 : cfg_data[1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg      <= '0;
            alpha_reg    <= AlphaDefault;
            stable_reg   <= StableDefault;
            offset_reg   <= '0;
            fx_reg       <= '0;
            fy_reg       <= '0;
            have_reg     <= 1'b0;
            heading_reg  <= '0;
            cand_reg     <= '0;
            rot_reg      <= '0;
            count_reg    <= '0;
            accepted_reg <= 1'b0;
            changed_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MIN_FIELD: min_reg    <= cfg_data[15:0];
                    CFG_ALPHA:     alpha_reg  <= cfg_data;
                    CFG_STABLE:    stable_reg <= cfg_data[15:0];
                    CFG_OFFSET:    offset_reg <= cfg_data[15:0];
                    CFG_INIT_ROT:
                    begin
                        rot_reg   <= rot_init;
                        cand_reg  <= rot_init;
                        count_reg <= '0;
                    end
                    default: ;
                endcase
            end
            unique case (cmd.op)
                OP_LOAD:
                begin
                    accepted_reg <= 1'b0;
                    changed_reg  <= 1'b0;
                end
                OP_CHECK: accepted_reg <= status.sample_ok;
                OP_FIRST:
                begin
                    fx_reg   <= vx_reg;
                    fy_reg   <= vy_reg;
                    have_reg <= 1'b1;
                end
                OP_BW:
                begin
                    if (cmd.comp)
                        fy_reg <= bw_val;
                    else
                        fx_reg <= bw_val;
                end
                OP_FLOAD:
                begin
                    fx_reg <= vx_reg;
                    fy_reg <= vy_reg;
                end
                OP_HEAD: heading_reg <= heading_next;
                OP_DEB:
                begin
                    if (cand_calc_reg != cand_reg)
                    begin
                        cand_reg  <= cand_calc_reg;
                        count_reg <= 16'd1;
                    end
                    else if (cand_reg != rot_reg && count_inc >= need)
                    begin
                        rot_reg     <= cand_reg;
                        count_reg   <= '0;
                        changed_reg <= 1'b1;
                    end
                    else
                    begin
                        count_reg <= count_inc;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                vx_reg <= $signed(in_x);
                vy_reg <= $signed(in_y);
            end
            OP_SQX:   ssum_reg  <= prod[31:0];
            OP_SQY:   ssum_reg  <= ssum_reg + prod[31:0];
            OP_MINSQ: minsq_reg <= prod[31:0];
            OP_DIVI:
            begin
                r_reg   <= {1'b0, prod[31:1]};
                lsb_reg <= prod[0];
                q_reg   <= '0;
            end
            OP_DIV:
            begin
                q_reg <= {q_reg[29:0], r_ge};
                r_reg <= r_ge ? rdiff[31:0] : r2[31:0];
            end
            OP_SQI:
            begin
                sv_reg  <= {1'b0, q_reg};
                res_reg <= '0;
                bit_reg <= SqrtBitInit;
            end
            OP_SQRT:
            begin
                if (sv_reg >= sq_sum)
                begin
                    sv_reg  <= sv_reg - sq_sum;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            OP_NWR:
            begin
                if (cmd.comp)
                    vy_reg <= norm_val;
                else
                    vx_reg <= norm_val;
            end
            OP_B1: t_reg <= prod;
            OP_B2: t_reg <= t_reg + prod;
            OP_FCOPY:
            begin
                vx_reg <= fx_reg;
                vy_reg <= fy_reg;
            end
            OP_CORI:
            begin
                if (fx_reg < 0)
                begin
                    cx_reg <= -xi;
                    cy_reg <= -yi;
                    cz_reg <= Z180;
                end
                else
                begin
                    cx_reg <= xi;
                    cy_reg <= yi;
                    cz_reg <= '0;
                end
            end
            OP_COR:
            begin
                if (cy_reg >= 0)
                begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    cz_reg <= cz_reg + atan_v;
                end
                else
                begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    cz_reg <= cz_reg - atan_v;
                end
            end
            OP_SECT: cand_calc_reg <= cand_next;
            default: ;
        endcase
    end

    assign status.sample_ok   = (ssum_reg != 32'd0) && (ssum_reg >= minsq_reg);
    assign status.have_sample = have_reg;
    assign status.sum_zero    = (ssum_reg == 32'd0);

    assign accepted  = accepted_reg;
    assign heading   = heading_reg;
    assign candidate = cand_reg;
    assign rotation  = rot_reg;
    assign changed   = changed_reg;

endmodule

/* src/mhsd_ctrl.sv */
// ----------------------------------------------------------------------------
// mhsd_ctrl
// Sequencer: threshold, normalization, filter, CORDIC, sector, debounce.
// ----------------------------------------------------------------------------
module mhsd_ctrl
    import mhsd_pkg::*;
#(
    parameter int unsigned CORDIC_STEPS = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    out_free,
    input  status_t status,
    output logic    in_ready,
    output logic    out_load,
    output cmd_t    cmd
);

    localparam logic [StepW-1:0] CorLast = StepW'(CORDIC_STEPS - 1);

    typedef enum logic [4:0] {
        S_IDLE, S_SQX, S_SQY, S_MINSQ, S_CHECK,
        S_DIVI, S_DIV, S_SQI, S_SQRT, S_NWR,
        S_FILT, S_B1, S_B2, S_BW,
        S_FCOPY, S_FSQX, S_FSQY, S_FCHK, S_FLOAD,
        S_CORI, S_COR, S_HEAD, S_SECT, S_DEB, S_DONE
    } state_t;

    state_t           state_reg;
    logic [StepW-1:0] count_reg;
    logic             comp_reg;
    logic             pass_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            comp_reg  <= 1'b0;
            pass_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:  if (in_valid) state_reg <= S_SQX;
                S_SQX:   state_reg <= S_SQY;
                S_SQY:   state_reg <= S_MINSQ;
                S_MINSQ: state_reg <= S_CHECK;
                S_CHECK:
                begin
                    comp_reg  <= 1'b0;
                    pass_reg  <= 1'b0;
                    state_reg <= status.sample_ok ? S_DIVI : S_DONE;
                end
                S_DIVI:
                begin
                    count_reg <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    count_reg <= count_reg + 1'b1;
                    if (count_reg == DivLast)
                        state_reg <= S_SQI;
                end
                S_SQI:
                begin
                    count_reg <= '0;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    count_reg <= count_reg + 1'b1;
                    if (count_reg == SqrtLast)
                        state_reg <= S_NWR;
                end
                S_NWR:
                begin
                    if (!comp_reg)
                    begin
                        comp_reg  <= 1'b1;
                        state_reg <= S_DIVI;
                    end
                    else
                    begin
                        state_reg <= pass_reg ? S_FLOAD : S_FILT;
                    end
                end
                S_FILT:
                begin
                    comp_reg  <= 1'b0;
                    state_reg <= status.have_sample ? S_B1 : S_CORI;
                end
                S_B1: state_reg <= S_B2;
                S_B2: state_reg <= S_BW;
                S_BW:
                begin
                    comp_reg  <= ~comp_reg;
                    state_reg <= comp_reg ? S_FCOPY : S_B1;
                end
                S_FCOPY: state_reg <= S_FSQX;
                S_FSQX:  state_reg <= S_FSQY;
                S_FSQY:  state_reg <= S_FCHK;
                S_FCHK:
                begin
                    comp_reg  <= 1'b0;
                    pass_reg  <= 1'b1;
                    state_reg <= status.sum_zero ? S_CORI : S_DIVI;
                end
                S_FLOAD: state_reg <= S_CORI;
                S_CORI:
                begin
                    count_reg <= '0;
                    state_reg <= S_COR;
                end
                S_COR:
                begin
                    count_reg <= count_reg + 1'b1;
                    if (count_reg == CorLast)
                        state_reg <= S_HEAD;
                end
                S_HEAD: state_reg <= S_SECT;
                S_SECT: state_reg <= S_DEB;
                S_DEB:  state_reg <= S_DONE;
                S_DONE: if (out_free) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd.comp = comp_reg;
        cmd.step = count_reg;
        unique case (state_reg)
            S_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NONE;
            S_SQX:   cmd.op = OP_SQX;
            S_SQY:   cmd.op = OP_SQY;
            S_MINSQ: cmd.op = OP_MINSQ;
            S_CHECK: cmd.op = OP_CHECK;
            S_DIVI:  cmd.op = OP_DIVI;
            S_DIV:   cmd.op = OP_DIV;
            S_SQI:   cmd.op = OP_SQI;
            S_SQRT:  cmd.op = OP_SQRT;
            S_NWR:   cmd.op = OP_NWR;
            S_FILT:  cmd.op = status.have_sample ? OP_NONE : OP_FIRST;
            S_B1:    cmd.op = OP_B1;
            S_B2:    cmd.op = OP_B2;
            S_BW:    cmd.op = OP_BW;
            S_FCOPY: cmd.op = OP_FCOPY;
            S_FSQX:  cmd.op = OP_SQX;
            S_FSQY:  cmd.op = OP_SQY;
            S_FLOAD: cmd.op = OP_FLOAD;
            S_CORI:  cmd.op = OP_CORI;
            S_COR:   cmd.op = OP_COR;
            S_HEAD:  cmd.op = OP_HEAD;
            S_SECT:  cmd.op = OP_SECT;
            S_DEB:   cmd.op = OP_DEB;
            default: cmd.op = OP_NONE;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_load = (state_reg == S_DONE) && out_free;

endmodule

/* src/magnetic_heading_sector_debounce_unit.sv */
// ----------------------------------------------------------------------------
// magnetic_heading_sector_debounce_unit
// A dropped sample goes from the threshold check straight to the output; the
// first accepted sample skips the filter blend and the second normalization
// pass; the divider and square root (31 + 16 steps per component) dominate.
// Throughput: one beat at a time; the next beat is taken once the result sits
// in the output register. Reset clears filter, heading and rotation and
// restores the register defaults.
// ----------------------------------------------------------------------------
module magnetic_heading_sector_debounce_unit
    import mhsd_pkg::*;
#(
    parameter int unsigned CORDIC_STEPS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [31:0]         s_axis_tdata,   // mag_x, mag_y
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [23:0]         m_axis_tdata,   // accepted, heading, candidate_sector,
                                                // rotation, changed, zero pad
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    cmd_t        cmd;
    status_t     status;
    logic        out_free, out_load;
    logic        accepted, changed;
    logic [15:0] heading;
    logic [1:0]  candidate, rotation;
    logic        out_valid_reg;
    logic [23:0] out_data_reg;

    assign out_free = !out_valid_reg || m_axis_tready;

    mhsd_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .out_free (out_free),
        .status   (status),
        .in_ready (s_axis_tready),
        .out_load (out_load),
        .cmd      (cmd)
    );

    mhsd_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_x      (s_axis_tdata[15:0]),
        .in_y      (s_axis_tdata[31:16]),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .accepted  (accepted),
        .heading   (heading),
        .candidate (candidate),
        .rotation  (rotation),
        .changed   (changed)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= {2'b0, changed, rotation, candidate, heading, accepted};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
